FILE: rtl/ahs_pkg.sv
// Shared types and constants for the actuator homing sequencer.
`default_nettype none

package ahs_pkg;

    // Default width of the timestamp arithmetic
    localparam int TIME_BITS_DEF = 32;

    // Register reset values
    localparam logic        EXTEND_LEVEL_RESET = 1'b1;
    localparam logic        SHRINK_LEVEL_RESET = 1'b1;
    localparam logic [31:0] TIMEOUT_RESET      = 32'd10000;

    // Middle position is half the extend travel: divide by two as a shift
    localparam int MIDDLE_SHIFT = 1;

    // Request codes
    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_EXTEND = 3'd1,
        REQ_SHRINK = 3'd2,
        REQ_STOP   = 3'd3,
        REQ_HOME   = 3'd4
    } req_t;

    // Motion state
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_EXTEND = 2'd1,
        MODE_SHRINK = 2'd2,
        MODE_ERROR  = 2'd3
    } mode_t;

    // Homing phases
    typedef enum logic [1:0] {
        PHASE_RETRACT     = 2'd0,
        PHASE_EXT_MEASURE = 2'd1,
        PHASE_SHR_MEASURE = 2'd2,
        PHASE_MIDDLE      = 2'd3
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_EXTEND_LEVEL = 2'd0,
        CFG_SHRINK_LEVEL = 2'd1,
        CFG_TIMEOUT      = 2'd2
    } cfg_idx_t;

    // One input item
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_time;
        logic        extend_limit_hit;
        logic        shrink_limit_hit;
    } item_t;

    // Configuration seen by the core
    typedef struct packed {
        logic        extend_level;
        logic        shrink_level;
        logic [31:0] homing_timeout;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic        extend_drive;
        logic        shrink_drive;
        logic        extend_led;
        logic        shrink_led;
        logic [1:0]  motion_state;
        logic        homing_active;
        logic [1:0]  homing_step;
        logic [31:0] extend_travel;
        logic [31:0] shrink_travel;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/ahs_core.sv
// Controller state and the per-item update that produces one result.
`default_nettype none

module ahs_core #(
    parameter int TIME_BITS = ahs_pkg::TIME_BITS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              apply,
    input  ahs_pkg::item_t   item,
    input  ahs_pkg::cfg_t    cfg,
    output ahs_pkg::result_t res
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    // State registers
    ahs_pkg::mode_t         mode_reg, mode_next;
    logic                   homing_reg, homing_next;
    logic                   started_reg, started_next;
    ahs_pkg::phase_t        phase_reg, phase_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [TIME_BITS-1:0]   ext_ticks_reg, ext_ticks_next;
    logic [TIME_BITS-1:0]   shr_ticks_reg, shr_ticks_next;

    // Time arithmetic
    logic [CMP_W-1:0]       now_wide;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   half_ext;
    logic [CMP_W-1:0]       elapsed_wide;
    logic [CMP_W-1:0]       timeout_wide;
    logic                   over_time;
    logic                   advanced;
    logic [CMP_W-1:0]       ext_travel_wide;
    logic [CMP_W-1:0]       shr_travel_wide;
    logic                   ext_on;
    logic                   shr_on;

    always_comb
    begin
        now_wide     = CMP_W'(item.now_time);
        now_t        = now_wide[TIME_BITS-1:0];
        elapsed      = now_t - start_reg;
        half_ext     = ext_ticks_reg >> ahs_pkg::MIDDLE_SHIFT;
        elapsed_wide = CMP_W'(elapsed);
        timeout_wide = CMP_W'(cfg.homing_timeout);
        over_time    = elapsed_wide > timeout_wide;
    end

    // Next state for the item being applied
    always_comb
    begin
        mode_next      = mode_reg;
        homing_next    = homing_reg;
        started_next   = started_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        ext_ticks_next = ext_ticks_reg;
        shr_ticks_next = shr_ticks_reg;
        advanced       = 1'b0;

        unique case (item.req_type)
            ahs_pkg::REQ_TICK:
            begin
                if (homing_reg) begin
                    if (!started_reg) begin
                        // first tick of a homing run: begin retracting
                        started_next = 1'b1;
                        phase_next   = ahs_pkg::PHASE_RETRACT;
                        start_next   = now_t;
                        mode_next    = ahs_pkg::MODE_SHRINK;
                    end else begin
                        unique case (phase_reg)
                            ahs_pkg::PHASE_RETRACT:
                            begin
                                if (mode_reg == ahs_pkg::MODE_SHRINK
                                    && item.shrink_limit_hit) begin
                                    advanced   = 1'b1;
                                    phase_next = ahs_pkg::PHASE_EXT_MEASURE;
                                    start_next = now_t;
                                    mode_next  = ahs_pkg::MODE_EXTEND;
                                end
                            end
                            ahs_pkg::PHASE_EXT_MEASURE:
                            begin
                                if (mode_reg == ahs_pkg::MODE_EXTEND
                                    && item.extend_limit_hit) begin
                                    advanced       = 1'b1;
                                    ext_ticks_next = elapsed;
                                    phase_next     = ahs_pkg::PHASE_SHR_MEASURE;
                                    start_next     = now_t;
                                    mode_next      = ahs_pkg::MODE_SHRINK;
                                end
                            end
                            ahs_pkg::PHASE_SHR_MEASURE:
                            begin
                                if (mode_reg == ahs_pkg::MODE_SHRINK
                                    && item.shrink_limit_hit) begin
                                    advanced       = 1'b1;
                                    shr_ticks_next = elapsed;
                                    phase_next     = ahs_pkg::PHASE_MIDDLE;
                                    start_next     = now_t;
                                    mode_next      = ahs_pkg::MODE_EXTEND;
                                end
                            end
                            ahs_pkg::PHASE_MIDDLE:
                            begin
                                if (elapsed >= half_ext) begin
                                    mode_next   = ahs_pkg::MODE_IDLE;
                                    homing_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                        // a phase that just advanced restarted its timer
                        if (!advanced && over_time) begin
                            mode_next   = ahs_pkg::MODE_ERROR;
                            homing_next = 1'b0;
                        end
                    end
                end else if (mode_reg == ahs_pkg::MODE_EXTEND && item.extend_limit_hit) begin
                    mode_next = ahs_pkg::MODE_IDLE;
                end else if (mode_reg == ahs_pkg::MODE_SHRINK && item.shrink_limit_hit) begin
                    mode_next = ahs_pkg::MODE_IDLE;
                end else if (mode_reg == ahs_pkg::MODE_ERROR) begin
                    mode_next = ahs_pkg::MODE_IDLE;
                end
            end
            ahs_pkg::REQ_EXTEND: mode_next = ahs_pkg::MODE_EXTEND;
            ahs_pkg::REQ_SHRINK: mode_next = ahs_pkg::MODE_SHRINK;
            ahs_pkg::REQ_STOP:   mode_next = ahs_pkg::MODE_IDLE;
            ahs_pkg::REQ_HOME:
            begin
                homing_next    = 1'b1;
                started_next   = 1'b0;
                phase_next     = ahs_pkg::PHASE_RETRACT;
                start_next     = '0;
                ext_ticks_next = '0;
                shr_ticks_next = '0;
                mode_next      = ahs_pkg::MODE_SHRINK;
            end
            default:
            begin
                // unused codes leave the state alone
                mode_next = mode_reg;
            end
        endcase
    end

    // Result from the updated state
    always_comb
    begin
        ext_on          = (mode_next == ahs_pkg::MODE_EXTEND);
        shr_on          = (mode_next == ahs_pkg::MODE_SHRINK);
        ext_travel_wide = CMP_W'(ext_ticks_next);
        shr_travel_wide = CMP_W'(shr_ticks_next);

        res.extend_drive  = ext_on ? cfg.extend_level : ~cfg.extend_level;
        res.shrink_drive  = shr_on ? cfg.shrink_level : ~cfg.shrink_level;
        res.extend_led    = ext_on;
        res.shrink_led    = shr_on;
        res.motion_state  = mode_next;
        res.homing_active = homing_next;
        res.homing_step   = phase_next;
        res.extend_travel = ext_travel_wide[31:0];
        res.shrink_travel = shr_travel_wide[31:0];
    end

    // State update, one item per cycle while apply is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= ahs_pkg::MODE_IDLE;
            homing_reg    <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= ahs_pkg::PHASE_RETRACT;
            start_reg     <= '0;
            ext_ticks_reg <= '0;
            shr_ticks_reg <= '0;
        end else if (apply) begin
            mode_reg      <= mode_next;
            homing_reg    <= homing_next;
            started_reg   <= started_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            ext_ticks_reg <= ext_ticks_next;
            shr_ticks_reg <= shr_ticks_next;
        end
    end

    // Phase moves only when an item is applied
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !apply |=> $stable(phase_reg))
        else $error("homing phase changed without an item");

    // A tick advances the phase by at most one
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        apply && item.req_type == ahs_pkg::REQ_TICK |=>
            (phase_reg == $past(phase_reg)) || (phase_reg == $past(phase_reg) + 1))
        else $error("homing phase skipped");

    // Homing only starts on a start-homing request
    a_homing_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(homing_reg) |-> $past(apply && item.req_type == ahs_pkg::REQ_HOME))
        else $error("homing started without request");

    // Start-homing always enters the retract phase while shrinking
    a_home_entry: assert property (@(posedge clk) disable iff (!rst_n)
        apply && item.req_type == ahs_pkg::REQ_HOME |=>
            homing_reg && !started_reg && phase_reg == ahs_pkg::PHASE_RETRACT
            && mode_reg == ahs_pkg::MODE_SHRINK)
        else $error("bad homing entry state");

endmodule

`default_nettype wire

FILE: rtl/actuator_homing_sequencer_top.sv
// Top level: stream ports, configuration registers, input and result registers.
//
// Linear actuator controller with a four-phase homing sequence.
// Input stream (s_*): one transfer is a tick or a command; s_tuser holds the
// request code, s_tdata the timestamp and the two debounced limit flags.
// Output stream (m_*): exactly one result transfer per input transfer, in
// order: drive levels, LEDs, motion state, homing status and the measured
// travel times.
// Configuration: cfg_we/cfg_addr/cfg_data write the drive active levels and
// the per-phase homing timeout; write only while no item is in flight.
// Path: input register, then update logic into the result register.
// Throughput: one item per cycle while m_tready is high; the state update is a
// single pass of logic between the input register and the result register.
// Reset: both stream registers empty, actuator idle, homing off, levels 1,
// timeout 10000 ticks.
// Stall: when m_tready is low the result holds; one more item may wait in
// the input register, after which s_tready drops.
`default_nettype none

module actuator_homing_sequencer_top #(
    parameter int TIME_BITS = ahs_pkg::TIME_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [39:0]  s_tdata,   // now_time[31:0], extend_limit_hit[32],
                                   // shrink_limit_hit[33], zero[39:34]
    input  wire [2:0]   s_tuser,   // req_type[2:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // extend_drive[0], shrink_drive[1],
                                   // extend_led[2], shrink_led[3],
                                   // motion_state[5:4], homing_active[6],
                                   // homing_step[8:7], extend_travel[40:9],
                                   // shrink_travel[72:41], zero[79:73]
    // configuration
    input  wire         cfg_we,
    input  wire [1:0]   cfg_addr,
    input  wire [31:0]  cfg_data
);

    logic             in_valid_reg, in_valid_next;
    ahs_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    ahs_pkg::result_t out_res_reg;
    ahs_pkg::result_t core_res;
    ahs_pkg::cfg_t    cfg_reg;
    ahs_pkg::item_t   s_item;
    logic             s_fire;
    logic             advance;
    logic             apply;

    // Handshake control
    always_comb
    begin
        advance  = !out_valid_reg || m_tready;
        apply    = in_valid_reg && advance;
        s_tready = !in_valid_reg || advance;
        s_fire   = s_tvalid && s_tready;

        s_item.req_type         = s_tuser;
        s_item.now_time         = s_tdata[31:0];
        s_item.extend_limit_hit = s_tdata[32];
        s_item.shrink_limit_hit = s_tdata[33];

        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (apply) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (apply) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (apply) begin
            out_res_reg <= core_res;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.extend_level   <= ahs_pkg::EXTEND_LEVEL_RESET;
            cfg_reg.shrink_level   <= ahs_pkg::SHRINK_LEVEL_RESET;
            cfg_reg.homing_timeout <= ahs_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ahs_pkg::CFG_EXTEND_LEVEL: cfg_reg.extend_level   <= cfg_data[0];
                ahs_pkg::CFG_SHRINK_LEVEL: cfg_reg.shrink_level   <= cfg_data[0];
                ahs_pkg::CFG_TIMEOUT:      cfg_reg.homing_timeout <= cfg_data;
                default:                   cfg_reg                <= cfg_reg;
            endcase
        end
    end

    ahs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (apply),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    // Result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_res_reg.shrink_travel,
                       out_res_reg.extend_travel,
                       out_res_reg.homing_step,
                       out_res_reg.homing_active,
                       out_res_reg.motion_state,
                       out_res_reg.shrink_led,
                       out_res_reg.extend_led,
                       out_res_reg.shrink_drive,
                       out_res_reg.extend_drive};

endmodule

`default_nettype wire
